// File: sv/sbg_pkg.sv
// Shared types, constants and the sigmoid point table for the SiLU backward block.
// Used by every module of the block; depends on nothing else.
package sbg_pkg;

  localparam int DATA_WIDTH       = 16;
  localparam int FRAC_BITS        = 12;
  localparam int SIGMOID_SEGMENTS = 64;

  localparam int IDX_BITS  = $clog2(SIGMOID_SEGMENTS);
  localparam int SPAN_BITS = FRAC_BITS + 4;            // span of [-8, 8) is 16 << FRAC_BITS
  localparam int OFF_BITS  = DATA_WIDTH + 2;
  localparam int P_BITS    = SPAN_BITS + IDX_BITS;
  localparam int S28_BITS  = 29;                       // 0 .. 1.0 in Q28
  localparam int TP_BITS   = 46;                       // x times (1 - s)
  localparam int T_BITS    = TP_BITS - FRAC_BITS;
  localparam int OPT_BITS  = 33;                       // 1 + t, |1 + t| < 8 in Q28
  localparam int GP_BITS   = S28_BITS + 1 + OPT_BITS;
  localparam int G_BITS    = 32;                       // |g| < 8 in Q28
  localparam int TERM_PROD_BITS = 48;
  localparam int TERM_BITS = TERM_PROD_BITS - 28;
  localparam int SUM_BITS  = TERM_BITS + 1;

  localparam logic [31:0] ONE31 = 32'h8000_0000;
  localparam logic [S28_BITS-1:0] ONE28 = S28_BITS'(1) << 28;
  localparam logic signed [TERM_PROD_BITS-1:0] ROUND_HALF = TERM_PROD_BITS'(1) << 27;
  localparam logic signed [OFF_BITS-1:0] OFF_BIAS = OFF_BITS'(8) << FRAC_BITS;
  localparam logic signed [OFF_BITS-1:0] OFF_SPAN = OFF_BITS'(1) << SPAN_BITS;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_BITS'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = -SUM_MAX - SUM_BITS'(1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  // Fields that ride along the pipeline next to the sigmoid datapath.
  typedef struct packed {
    word_t x_value;
    word_t grad_out;
    word_t grad_acc_before;
    logic  last_element;
  } side_t;

  typedef logic [31:0] sig_table_t [0:SIGMOID_SEGMENTS];

  // Unsigned quotient by shift and compare-subtract, used only while the
  // point table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid at evenly spaced points over [-8, 8], unsigned Q31. Evaluated at
  // elaboration: exp(-|t|) from a quartic of |t|/256, squared eight times.
  function automatic sig_table_t build_sig_table();
    sig_table_t  tbl;
    longint      num;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] u4;
    logic [63:0] e;
    logic [63:0] p;
    for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
      num = 16 * longint'(k) - 8 * longint'(SIGMOID_SEGMENTS);
      neg = (num < 0);
      mag = neg ? 64'(-num) : 64'(num);
      u   = div_u64(mag << 23, 64'(SIGMOID_SEGMENTS));
      u2  = (u * u) >> 31;
      u3  = (u2 * u) >> 31;
      u4  = (u3 * u) >> 31;
      e   = 64'(ONE31) - u + (u2 >> 1) - div_u64(u3, 64'd6) + div_u64(u4, 64'd24);
      for (int i = 0; i < 8; i++) begin
        e = (e * e) >> 31;
      end
      p = div_u64(64'd1 << 62, 64'(ONE31) + e);
      tbl[k] = neg ? 32'(64'(ONE31) - p) : 32'(p);
    end
    return tbl;
  endfunction

endpackage

// File: sv/sbg_sigmoid.sv
// Three-stage piecewise-linear sigmoid: table lookup, slope product, blend.
// Depends on sbg_pkg for the point table, widths and the side-band struct.
module sbg_sigmoid (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  sbg_pkg::side_t                  in_side,
  output logic                            out_valid,
  output sbg_pkg::side_t                  out_side,
  output logic [sbg_pkg::S28_BITS-1:0]    out_s28,
  output logic [sbg_pkg::S28_BITS-1:0]    out_om
);

  localparam sbg_pkg::sig_table_t SIG_TABLE = sbg_pkg::build_sig_table();

  // Stage 1: offset into the table, index and remainder.
  logic signed [sbg_pkg::OFF_BITS-1:0] off;
  logic [sbg_pkg::P_BITS-1:0]          pos;
  logic [sbg_pkg::IDX_BITS:0]          idx;
  logic [sbg_pkg::IDX_BITS:0]          idx_hi;

  logic                           v1_r;
  sbg_pkg::side_t                 side1_r;
  logic [31:0]                    y0_1_r;
  logic [31:0]                    y1_1_r;
  logic [sbg_pkg::SPAN_BITS-1:0]  rem1_r;
  logic                           low1_r;
  logic                           high1_r;

  assign off    = {{(sbg_pkg::OFF_BITS - sbg_pkg::DATA_WIDTH){in_side.x_value[sbg_pkg::DATA_WIDTH-1]}},
                   in_side.x_value} + sbg_pkg::OFF_BIAS;
  assign pos    = sbg_pkg::P_BITS'(off[sbg_pkg::SPAN_BITS-1:0]) *
                  sbg_pkg::P_BITS'(sbg_pkg::SIGMOID_SEGMENTS);
  assign idx    = {1'b0, pos[sbg_pkg::P_BITS-1:sbg_pkg::SPAN_BITS]};
  assign idx_hi = idx + (sbg_pkg::IDX_BITS+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= in_side;
    y0_1_r  <= SIG_TABLE[idx];
    y1_1_r  <= SIG_TABLE[idx_hi];
    rem1_r  <= pos[sbg_pkg::SPAN_BITS-1:0];
    low1_r  <= (off < 0);
    high1_r <= (off >= sbg_pkg::OFF_SPAN);
  end

  // Stage 2: magnitude of the slope times the remainder.
  logic signed [32:0] dif;
  logic [31:0]        dif_mag;

  logic                                    v2_r;
  sbg_pkg::side_t                          side2_r;
  logic [31:0]                             y0_2_r;
  logic [31+sbg_pkg::SPAN_BITS:0]          prod2_r;
  logic                                    neg2_r;
  logic                                    low2_r;
  logic                                    high2_r;

  assign dif     = $signed({1'b0, y1_1_r}) - $signed({1'b0, y0_1_r});
  assign dif_mag = dif[32] ? 32'(-dif) : dif[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    side2_r <= side1_r;
    y0_2_r  <= y0_1_r;
    prod2_r <= (32 + sbg_pkg::SPAN_BITS)'(dif_mag) * (32 + sbg_pkg::SPAN_BITS)'(rem1_r);
    neg2_r  <= dif[32];
    low2_r  <= low1_r;
    high2_r <= high1_r;
  end

  // Stage 3: blend, drop to Q28 and form 1 - s.
  logic [31:0] quot;
  logic [31:0] s31;
  logic [sbg_pkg::S28_BITS-1:0] s28_nxt;

  logic                         v3_r;
  sbg_pkg::side_t               side3_r;
  logic [sbg_pkg::S28_BITS-1:0] s28_r;
  logic [sbg_pkg::S28_BITS-1:0] om_r;

  assign quot = prod2_r[31+sbg_pkg::SPAN_BITS:sbg_pkg::SPAN_BITS];

  always_comb begin
    priority if (low2_r) begin
      s31 = '0;
    end else if (high2_r) begin
      s31 = sbg_pkg::ONE31;
    end else if (neg2_r) begin
      s31 = y0_2_r - quot;
    end else begin
      s31 = y0_2_r + quot;
    end
  end

  assign s28_nxt = s31[31:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    s28_r   <= s28_nxt;
    om_r    <= sbg_pkg::ONE28 - s28_nxt;
  end

  assign out_valid = v3_r;
  assign out_side  = side3_r;
  assign out_s28   = s28_r;
  assign out_om    = om_r;

endmodule

// File: sv/sbg_gradient.sv
// Four-stage product chain: t = x(1 - s), g = s(1 + t), then dy * g plus rounding half.
// Depends on sbg_pkg for widths, constants and the side-band struct.
module sbg_gradient (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  sbg_pkg::side_t                        in_side,
  input  logic [sbg_pkg::S28_BITS-1:0]          in_s28,
  input  logic [sbg_pkg::S28_BITS-1:0]          in_om,
  output logic                                  out_valid,
  output sbg_pkg::side_t                        out_side,
  output logic signed [sbg_pkg::TERM_PROD_BITS-1:0] out_term_prod
);

  // Stage 4: x times (1 - s).
  logic                                  v4_r;
  sbg_pkg::side_t                        side4_r;
  logic [sbg_pkg::S28_BITS-1:0]          s28_4_r;
  logic signed [sbg_pkg::TP_BITS-1:0]    tp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side4_r <= in_side;
    s28_4_r <= in_s28;
    tp4_r   <= $signed(in_side.x_value) * $signed({1'b0, in_om});
  end

  // Stage 5: floor to Q28 and add one.
  logic signed [sbg_pkg::T_BITS-1:0] t_val;
  logic signed [sbg_pkg::T_BITS:0]   opt_full;

  logic                                v5_r;
  sbg_pkg::side_t                      side5_r;
  logic [sbg_pkg::S28_BITS-1:0]        s28_5_r;
  logic signed [sbg_pkg::OPT_BITS-1:0] opt5_r;

  assign t_val    = tp4_r[sbg_pkg::TP_BITS-1:sbg_pkg::FRAC_BITS];
  assign opt_full = {t_val[sbg_pkg::T_BITS-1], t_val} +
                    $signed((sbg_pkg::T_BITS+1)'(sbg_pkg::ONE28));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    side5_r <= side4_r;
    s28_5_r <= s28_4_r;
    opt5_r  <= opt_full[sbg_pkg::OPT_BITS-1:0];
  end

  // Stage 6: s times (1 + t).
  logic                                v6_r;
  sbg_pkg::side_t                      side6_r;
  logic signed [sbg_pkg::GP_BITS-1:0]  gp6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    side6_r <= side5_r;
    gp6_r   <= $signed({1'b0, s28_5_r}) * opt5_r;
  end

  // Stage 7: dy times g, with half an LSB added for rounding.
  logic signed [sbg_pkg::G_BITS-1:0] g_val;

  logic                                       v7_r;
  sbg_pkg::side_t                             side7_r;
  logic signed [sbg_pkg::TERM_PROD_BITS-1:0]  term7_r;

  assign g_val = gp6_r[sbg_pkg::G_BITS+27:28];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    side7_r <= side6_r;
    term7_r <= $signed(side6_r.grad_out) * g_val + sbg_pkg::ROUND_HALF;
  end

  assign out_valid     = v7_r;
  assign out_side      = side7_r;
  assign out_term_prod = term7_r;

endmodule

// File: sv/sbg_accum.sv
// Final stage: adds the gradient term to the accumulated gradient and saturates.
// Depends on sbg_pkg for widths, limits and the side-band struct.
module sbg_accum (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  sbg_pkg::side_t                            in_side,
  input  logic signed [sbg_pkg::TERM_PROD_BITS-1:0] in_term_prod,
  output logic                                      out_valid,
  output sbg_pkg::word_t                            out_sum,
  output logic                                      out_sat,
  output logic                                      out_last
);

  logic signed [sbg_pkg::TERM_BITS-1:0] term;
  logic signed [sbg_pkg::SUM_BITS-1:0]  sum;
  logic signed [sbg_pkg::SUM_BITS-1:0]  clip_nxt;
  logic                                 sat_nxt;

  logic           valid_r;
  sbg_pkg::word_t sum_r;
  logic           sat_r;
  logic           last_r;

  assign term = in_term_prod[sbg_pkg::TERM_PROD_BITS-1:28];
  assign sum  = sbg_pkg::SUM_BITS'(in_side.grad_acc_before) + sbg_pkg::SUM_BITS'(term);

  always_comb begin
    priority if (sum > sbg_pkg::SUM_MAX) begin
      clip_nxt = sbg_pkg::SUM_MAX;
      sat_nxt  = 1'b1;
    end else if (sum < sbg_pkg::SUM_MIN) begin
      clip_nxt = sbg_pkg::SUM_MIN;
      sat_nxt  = 1'b1;
    end else begin
      clip_nxt = sum;
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= clip_nxt[sbg_pkg::DATA_WIDTH-1:0];
    sat_r  <= sat_nxt;
    last_r <= in_side.last_element;
  end

  assign out_valid = valid_r;
  assign out_sum   = sum_r;
  assign out_sat   = sat_r;
  assign out_last  = last_r;

endmodule

// File: sv/silu_backward_gradient.sv
// Top level of the SiLU backward gradient block in signed Q4.12.
// Depends on sbg_pkg, sbg_sigmoid, sbg_gradient and sbg_accum.
//
// This block takes one word per clock and returns one word per clock for as long as
// start is held high. Each word computes
// dx + dy * s * (1 + x * (1 - s)) with s the sigmoid of x, clips the sum to the signed
// 16-bit range and raises out_saturated when it clips; out_last_out copies the
// last-element marker. busy never rises: the pipeline has no loop and no shared unit,
// so every stage moves forward each cycle, and since the receiver cannot hold results
// off, out_valid simply marks the cycle in which a result word is on the out_ ports.
// The pipeline is made of the three sigmoid stages (table lookup, slope product,
// blend), the four stages of the gradient term (x times 1 - s, the shift and add of
// one, s times 1 + t, dy times g) and the saturating adder. Words come out in the
// order they went in.
module silu_backward_gradient (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  sbg_pkg::word_t         in_x_value,
  input  sbg_pkg::word_t         in_grad_out,
  input  sbg_pkg::word_t         in_grad_acc_before,
  input  logic                   in_last_element,
  output logic                   out_valid,
  output sbg_pkg::word_t         out_grad_acc_after,
  output logic                   out_saturated,
  output logic                   out_last_out
);

  sbg_pkg::side_t in_side;
  logic           in_take;

  // The forward input and both gradients travel in one side-band word so every
  // stage carries the same fields next to its valid bit.
  assign in_side.x_value         = in_x_value;
  assign in_side.grad_out        = in_grad_out;
  assign in_side.grad_acc_before = in_grad_acc_before;
  assign in_side.last_element    = in_last_element;

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  logic                         sig_valid;
  sbg_pkg::side_t               sig_side;
  logic [sbg_pkg::S28_BITS-1:0] sig_s28;
  logic [sbg_pkg::S28_BITS-1:0] sig_om;

  sbg_sigmoid u_sigmoid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_take),
    .in_side   (in_side),
    .out_valid (sig_valid),
    .out_side  (sig_side),
    .out_s28   (sig_s28),
    .out_om    (sig_om)
  );

  logic                                      grd_valid;
  sbg_pkg::side_t                            grd_side;
  logic signed [sbg_pkg::TERM_PROD_BITS-1:0] grd_term_prod;

  sbg_gradient u_gradient (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sig_valid),
    .in_side       (sig_side),
    .in_s28        (sig_s28),
    .in_om         (sig_om),
    .out_valid     (grd_valid),
    .out_side      (grd_side),
    .out_term_prod (grd_term_prod)
  );

  // The last stage registers the result ports directly.
  sbg_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (grd_valid),
    .in_side      (grd_side),
    .in_term_prod (grd_term_prod),
    .out_valid    (out_valid),
    .out_sum      (out_grad_acc_after),
    .out_sat      (out_saturated),
    .out_last     (out_last_out)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for silu_backward_gradient, the SiLU backward gradient block.
// Depends on sbg_pkg for the word type and sizes, and on the block itself.
`timescale 1ns / 100ps

module testbench;

  // Sizes and constants of the fixed-point gradient calculation.
  localparam longint Q31_ONE   = longint'(1) << 31;
  localparam longint Q28_ONE   = longint'(1) << 28;
  localparam longint TABLE_SPAN = longint'(16) << sbg_pkg::FRAC_BITS;
  localparam longint GRAD_MAX  = (longint'(1) << (sbg_pkg::DATA_WIDTH - 1)) - 1;
  localparam longint GRAD_MIN  = -GRAD_MAX - 1;

  localparam sbg_pkg::word_t WORD_MAX = 16'sh7fff;
  localparam sbg_pkg::word_t WORD_MIN = 16'sh8000;
  localparam sbg_pkg::word_t ONE_Q12  = 16'sh1000;

  // The random part runs about this many words; directed words come on top.
  localparam int RANDOM_WORDS = 1250;
  // Words per random stretch before the idling mode is drawn again.
  localparam int STRETCH_WORDS = 125;
  // Cycles with no accepted word on either side before the run is given up.
  localparam int IDLE_LIMIT = 500;
  // Cycles to wait after the last expected word.
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // One result word as the block should return it.
  typedef struct {
    sbg_pkg::word_t grad;
    logic           sat;
    logic           last;
  } grad_word_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sbg_pkg::word_t in_x_value = '0;
  sbg_pkg::word_t in_grad_out = '0;
  sbg_pkg::word_t in_grad_acc_before = '0;
  logic           in_last_element = 1'b0;
  logic           out_valid;
  sbg_pkg::word_t out_grad_acc_after;
  logic           out_saturated;
  logic           out_last_out;

  // Sigmoid knots in unsigned Q31, held as longint to keep the slope arithmetic signed.
  longint     sigmoid_knots [0:sbg_pkg::SIGMOID_SEGMENTS];
  // Result words predicted for accepted input words, oldest first.
  grad_word_t grad_words_due [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  // When clear, the sender puts no gap between words.
  bit         idle_enable = 1'b1;

  silu_backward_gradient uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_x_value        (in_x_value),
    .in_grad_out       (in_grad_out),
    .in_grad_acc_before(in_grad_acc_before),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_grad_acc_after(out_grad_acc_after),
    .out_saturated     (out_saturated),
    .out_last_out      (out_last_out)
  );

  // A 2 ns clock, high for the first half of each period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the result word for one input word. The sigmoid is interpolated
  // between knots, the gradient term is built in Q28 with floor shifts, rounded
  // half up into Q4.12, added to the accumulated gradient and clipped.
  function automatic grad_word_t predict_grad(sbg_pkg::word_t x, sbg_pkg::word_t dy,
                                              sbg_pkg::word_t dx, logic last);
    longint     offset;
    longint     pos;
    longint     knot;
    longint     frac;
    longint     base;
    longint     slope;
    longint     sig31;
    longint     sig28;
    longint     x_term;
    longint     gain;
    longint     term;
    longint     sum;
    grad_word_t r;
    offset = longint'(x) + (longint'(8) << sbg_pkg::FRAC_BITS);
    if (offset < 0) begin
      sig31 = 0;
    end else if (offset >= TABLE_SPAN) begin
      sig31 = Q31_ONE;
    end else begin
      pos   = offset * sbg_pkg::SIGMOID_SEGMENTS;
      knot  = pos / TABLE_SPAN;
      frac  = pos % TABLE_SPAN;
      base  = sigmoid_knots[knot];
      slope = sigmoid_knots[knot + 1] - base;
      // Signed division truncates toward zero, for falling and rising slopes alike.
      sig31 = base + (slope * frac) / TABLE_SPAN;
    end
    sig28  = sig31 >>> 3;
    x_term = (longint'(x) * (Q28_ONE - sig28)) >>> sbg_pkg::FRAC_BITS;
    gain   = (sig28 * (Q28_ONE + x_term)) >>> 28;
    term   = (longint'(dy) * gain + (longint'(1) << 27)) >>> 28;
    sum    = longint'(dx) + term;
    r.sat  = 1'b0;
    if (sum > GRAD_MAX) begin
      sum   = GRAD_MAX;
      r.sat = 1'b1;
    end else if (sum < GRAD_MIN) begin
      sum   = GRAD_MIN;
      r.sat = 1'b1;
    end
    r.grad = sbg_pkg::word_t'(sum);
    r.last = last;
    return r;
  endfunction

  // Mostly full-range values, with the two extremes and small magnitudes mixed in.
  function automatic sbg_pkg::word_t pick_word();
    unique case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return sbg_pkg::word_t'($urandom_range(0, 8191)) - sbg_pkg::word_t'(4096);
      default: return sbg_pkg::word_t'($urandom);
    endcase
  endfunction

  // Forward inputs favor the neighborhood of a sigmoid knot, where the
  // interpolation fraction is zero or nearly so.
  function automatic sbg_pkg::word_t pick_x();
    if ($urandom_range(0, 5) == 0) begin
      return WORD_MIN + sbg_pkg::word_t'(1024 * $urandom_range(0, 63)) +
             sbg_pkg::word_t'($urandom_range(0, 2)) - sbg_pkg::word_t'(1);
    end
    return pick_word();
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // Sends one input word. start is left high on return, so that a following word
  // with no gap keeps it high instead of dropping and raising it in the same step.
  // The word counts as accepted at the first rising edge with busy low.
  task automatic send_word(sbg_pkg::word_t x, sbg_pkg::word_t dy, sbg_pkg::word_t dx,
                           logic last);
    int gap;
    gap = idle_enable ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_x_value         <= x;
    in_grad_out        <= dy;
    in_grad_acc_before <= dx;
    in_last_element    <= last;
    do @(posedge clk); while (busy !== 1'b0);
    grad_words_due.push_back(predict_grad(x, dy, dx, last));
  endtask

  // Ends of the forward input range: x = -8 sits on the bottom knot, where the
  // sigmoid is close to zero and so is the gradient term; x just under 8 sits at
  // the top, where the term is close to dy. Zero gives half of dy.
  task automatic test_table_ends();
    send_word(WORD_MIN, WORD_MAX, 16'sh0000, 1'b0);
    send_word(WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
    send_word(WORD_MAX, ONE_Q12, 16'sh0000, 1'b0);
    send_word(WORD_MAX, WORD_MIN, 16'sh0000, 1'b0);
    send_word(16'sh0000, ONE_Q12, 16'sh0000, 1'b0);
    send_word(16'shffff, WORD_MAX, 16'sh0001, 1'b0);
    send_word(16'sh0001, WORD_MIN, 16'shffff, 1'b0);
  endtask

  // Sums past either end are clipped and flagged; sums on the ends are not.
  task automatic test_saturation();
    send_word(WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
    send_word(WORD_MAX, WORD_MIN, WORD_MIN, 1'b0);
    send_word(16'sh0000, 16'sh0000, WORD_MAX, 1'b0);
    send_word(16'sh0000, 16'sh0000, WORD_MIN, 1'b0);
    send_word(WORD_MAX, 16'sh0001, 16'sh7ffe, 1'b0);
  endtask

  // Inputs on and next to interior knots, on both sides of zero.
  task automatic test_segment_knots();
    send_word(WORD_MIN + sbg_pkg::word_t'(1024), ONE_Q12, 16'sh0000, 1'b0);
    send_word(WORD_MIN + sbg_pkg::word_t'(1023), ONE_Q12, 16'sh0000, 1'b0);
    send_word(16'shfc00, WORD_MAX, 16'sh0000, 1'b0);
    send_word(16'sh03ff, WORD_MAX, 16'sh0000, 1'b0);
    send_word(16'sh0400, WORD_MIN, 16'sh0000, 1'b0);
    send_word(16'sh7c00, WORD_MAX, 16'sh0000, 1'b0);
    send_word(16'sh7bff, WORD_MIN, 16'sh0000, 1'b0);
  endtask

  // The last-element marker must ride through untouched, back to back and alone.
  task automatic test_last_marker();
    send_word(WORD_MAX, WORD_MAX, WORD_MIN, 1'b1);
    send_word(WORD_MIN, WORD_MIN, WORD_MAX, 1'b1);
    send_word(16'sh2000, 16'shf000, 16'sh0100, 1'b0);
    send_word(16'she000, 16'sh1000, 16'shff00, 1'b1);
  endtask

  // Random words in stretches: most stretches idle at random between words,
  // some run back to back so the pipeline stays full.
  task automatic test_random_words();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % STRETCH_WORDS == 0) begin
        idle_enable = ($urandom_range(0, 2) != 0);
      end
      send_word(pick_x(), pick_word(), pick_word(), ($urandom_range(0, 7) == 0));
    end
    idle_enable = 1'b1;
  endtask

  // Each strobed result word is compared with the oldest prediction. An unknown
  // strobe is taken as a word, so that it shows up as a mismatch.
  always @(posedge clk) begin
    grad_word_t due;
    if (rst_n && out_valid !== 1'b0) begin
      if (grad_words_due.size() == 0) begin
        note_mismatch($sformatf("unexpected word grad=%0d sat=%b last=%b",
                                out_grad_acc_after, out_saturated, out_last_out));
      end else begin
        due = grad_words_due.pop_front();
        if (out_valid !== 1'b1 || out_grad_acc_after !== due.grad ||
            out_saturated !== due.sat || out_last_out !== due.last) begin
          note_mismatch($sformatf(
              "expected grad=%0d sat=%b last=%b, got valid=%b grad=%0d sat=%b last=%b",
              due.grad, due.sat, due.last, out_valid, out_grad_acc_after,
              out_saturated, out_last_out));
        end
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("silu_backward_gradient test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] u4;
    logic [63:0] e;
    logic [63:0] p;
    longint      arg;
    // Knot k is the sigmoid at -8 + 16k/SEGMENTS. exp(-|t|) comes from a quartic
    // of |t|/256 raised to the 256th power by eight squarings, all truncated Q31.
    for (int k = 0; k <= sbg_pkg::SIGMOID_SEGMENTS; k++) begin
      arg = 16 * longint'(k) - 8 * longint'(sbg_pkg::SIGMOID_SEGMENTS);
      mag = (arg < 0) ? 64'(-arg) : 64'(arg);
      u   = (mag << 23) / 64'(sbg_pkg::SIGMOID_SEGMENTS);
      u2  = (u * u) >> 31;
      u3  = (u2 * u) >> 31;
      u4  = (u3 * u) >> 31;
      e   = 64'(Q31_ONE) - u + u2 / 64'd2 - u3 / 64'd6 + u4 / 64'd24;
      repeat (8) e = (e * e) >> 31;
      p = (64'd1 << 62) / (64'(Q31_ONE) + e);
      sigmoid_knots[k] = (arg < 0) ? longint'(64'(Q31_ONE) - p) : longint'(p);
    end

    // Synchronous reset is held low from the start, then released before the first word.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_ends();
    test_saturation();
    test_segment_knots();
    test_last_marker();
    test_random_words();
    start <= 1'b0;

    // Wait for every predicted word, then a little longer to catch strays.
    while (grad_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("silu_backward_gradient test passed");
    end else begin
      $display("silu_backward_gradient test failed");
    end
    $finish;
  end

endmodule

// File: silu_backward_gradient.f
sv/sbg_pkg.sv
sv/sbg_sigmoid.sv
sv/sbg_gradient.sv
sv/sbg_accum.sv
sv/silu_backward_gradient.sv
tb/testbench.sv
